[rtl/htsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_pkg
// Shared constants and types for the Huffman tree stream decoder.
// ----------------------------------------------------------------------------
package htsd_pkg;
  localparam int MaxNodesDef    = 512;
  localparam int MaxDepthDef    = 32;
  localparam int SymbolCountDef = 256;

  localparam logic OpHeader = 1'b0;
  localparam logic OpBody   = 1'b1;

  localparam logic [1:0] KindSym   = 2'd0;
  localparam logic [1:0] KindEnd   = 2'd1;
  localparam logic [1:0] KindHdr   = 2'd2;
  localparam logic [1:0] KindOrder = 2'd3;

  localparam logic [2:0] PhEnd  = 3'd0;
  localparam logic [2:0] PhTree = 3'd1;
  localparam logic [2:0] PhBody = 3'd2;
  localparam logic [2:0] PhDone = 3'd3;
  localparam logic [2:0] PhFail = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic       last;
  } result_t;
endpackage

[rtl/htsd_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htsd_out_reg
// Single-entry output register for result requests.
// ----------------------------------------------------------------------------
module htsd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  htsd_pkg::result_t din,
  output logic              full,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  htsd_pkg::result_t r;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (m_axis_tready) begin
      full <= 1'b0;
    end
    if (load) begin
      r <= din;
    end
  end

  assign m_axis_tvalid = full;
  assign m_axis_tdata  = {6'd0, r.symbol, r.kind};
  assign m_axis_tlast  = r.last;
endmodule

[rtl/huffman_tree_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// An end-symbol byte is taken at accept; a tree byte steps through accept, node write and
// slot pop, then parent link patch and left slot push; an out-of-order or failed item adds an emit step.
// Body byte: child read and decide for each bit, plus an emit step for each result, held through
// any output stall; one request at a time, never overlapped.
// Throughput is set by the node table: each bit step needs the previous node read first.
// Reset (rst, synchronous, high) clears phase, counters, current node; tables not cleared.
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder_unit
// Builds a preorder Huffman tree from header bytes, then walks body bits.
// ----------------------------------------------------------------------------
module huffman_tree_stream_decoder_unit #(
  parameter int MAX_NODES    = htsd_pkg::MaxNodesDef,
  parameter int MAX_DEPTH    = htsd_pkg::MaxDepthDef,
  parameter int SYMBOL_COUNT = htsd_pkg::SymbolCountDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] kind, [9:2] symbol, rest zero
  output logic        m_axis_tlast
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int DW = $clog2(MAX_DEPTH);
  localparam int SW = $clog2(MAX_DEPTH + 1);

  // sequencer codes
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SHdr   = 3'd1; // slot stack read done, decide
  localparam logic [2:0] SRead  = 3'd2; // parent node read done, patch link
  localparam logic [2:0] SStep  = 3'd3; // child read issued
  localparam logic [2:0] SDec   = 3'd4; // child data valid, decide
  localparam logic [2:0] SEmit  = 3'd5; // one result to push

  localparam int EW = 2 * NW + 9; // leaf, sym, left, right

  logic [2:0]    st;
  logic [2:0]    phase;
  logic [SW-1:0] depth;
  logic [CW-1:0] nfree;
  logic [7:0]    endsym;
  logic [NW-1:0] cur;
  logic [NW-1:0] nxt;
  logic [7:0]    sh;
  logic [3:0]    bits;
  logic          hold;   // a decoded symbol waits until we know if it is the last one
  logic [7:0]    hsym;
  logic          endq;   // end result follows the one in pend
  htsd_pkg::result_t pend;

  // node table
  logic [EW-1:0] nodes [MAX_NODES];
  logic [EW-1:0] nrd;
  logic          nwe;
  logic [NW-1:0] nwa, nra;
  logic [EW-1:0] nwd;
  // slot stack: parent, side, want_leaf
  logic [NW+1:0] slots [MAX_DEPTH];
  logic [NW+1:0] srd;
  logic          swe;
  logic [DW-1:0] swa, sra;
  logic [NW+1:0] swd;

  always_ff @(posedge clk) begin
    if (nwe) nodes[nwa] <= nwd;
    nrd <= nodes[nra];
    if (swe) slots[swa] <= swd;
    srd <= slots[sra];
  end

  logic full, load;
  htsd_pkg::result_t res;
  htsd_out_reg u_out (
    .clk, .rst, .load, .din(res), .full,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );
  logic free_ok;
  assign free_ok = !full || m_axis_tready;

  assign s_axis_tready = (st == SIdle);
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // decoded node fields
  logic          n_leaf;
  logic [7:0]    n_sym;
  logic [NW-1:0] n_left, n_right;
  assign {n_leaf, n_sym, n_left, n_right} = nrd;

  // header pieces (slot at top of stack)
  logic          is_root;
  logic [NW-1:0] s_par;
  logic          s_side, s_leaf;
  assign is_root = (depth == '0);
  assign {s_par, s_side, s_leaf} = is_root ? '0 : srd;
  logic [SW:0]   base;
  assign base = is_root ? '0 : ({1'b0, depth} - 1'b1);
  logic bad;
  always_comb begin
    bad = 1'b0;
    if (nfree >= CW'(MAX_NODES)) bad = 1'b1;
    else if (s_leaf) bad = ({1'b0, sh} >= 9'(SYMBOL_COUNT));
    else bad = (sh > 8'd3) || (base + 2'd2 > (SW+1)'(MAX_DEPTH));
  end
  logic [NW-1:0] idx;
  assign idx = nfree[NW-1:0];
  logic [SW-1:0] d1;
  assign d1 = is_root ? depth : depth - 1'b1;

  // parent link update needs a read-modify-write; keep the read in a second step
  logic          link_pend;
  logic [NW-1:0] link_par;
  logic          link_side;
  logic [NW-1:0] link_idx;
  logic [1:0]    push_left;

  logic [NW-1:0] child;
  assign child = sh[0] ? n_right : n_left;

  always_comb begin
    nwe = 1'b0; nwa = idx; nwd = '0; nra = cur;
    swe = 1'b0; swa = '0; swd = '0; sra = DW'(depth - 1'b1);
    load = 1'b0; res = pend;
    case (st)
      SIdle: nra = cur;
      SHdr: begin
        if (!bad) begin
          nwe = 1'b1;
          nwd = {s_leaf, s_leaf ? sh : 8'd0, {NW{1'b0}}, {NW{1'b0}}};
          if (!s_leaf) begin
            swe = 1'b1; swa = DW'(d1);
            swd = {idx, 1'b1, ~sh[0]};
          end
        end
        nra = s_par;
      end
      SRead: begin
        // nrd holds parent; patch link, then push left slot
        nwe = link_pend; nwa = link_par;
        nwd = link_side ? {nrd[EW-1:NW], link_idx} : {nrd[EW-1:2*NW], link_idx, nrd[NW-1:0]};
        if (push_left[1]) begin
          swe = 1'b1; swa = DW'(depth - 1'b1); swd = {link_idx, 1'b0, push_left[0]};
        end
      end
      SStep: nra = child;
      // next node for the following bit: root after a leaf, else the child
      SDec: nra = n_leaf ? '0 : nxt;
      SEmit: load = free_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SIdle; phase <= htsd_pkg::PhEnd; depth <= '0; nfree <= '0;
      endsym <= '0; cur <= '0; hold <= 1'b0; endq <= 1'b0;
    end else begin
      case (st)
        SIdle: if (acc) begin
          sh <= s_axis_tdata; bits <= 4'd0; hold <= 1'b0; endq <= 1'b0;
          pend <= '{kind: (phase > htsd_pkg::PhDone) ? htsd_pkg::KindHdr
                                                      : htsd_pkg::KindOrder,
                    symbol: 8'd0, last: 1'b1};
          case (phase)
            htsd_pkg::PhEnd:
              if (s_axis_tuser == htsd_pkg::OpHeader) begin
                endsym <= s_axis_tdata; phase <= htsd_pkg::PhTree;
              end else st <= SEmit;
            htsd_pkg::PhTree:
              if (s_axis_tuser == htsd_pkg::OpHeader) st <= SHdr;
              else st <= SEmit;
            htsd_pkg::PhBody:
              if (s_axis_tuser == htsd_pkg::OpBody) st <= SStep;
              else st <= SEmit;
            htsd_pkg::PhDone: st <= SEmit;
            default: st <= SEmit;
          endcase
        end
        SHdr: begin
          if (bad) begin
            phase <= htsd_pkg::PhFail;
            pend <= '{kind: htsd_pkg::KindHdr, symbol: 8'd0, last: 1'b1};
            st <= SEmit;
          end else begin
            nfree <= nfree + 1'b1;
            link_pend <= !is_root; link_par <= s_par; link_side <= s_side;
            link_idx <= idx;
            push_left <= {!s_leaf, (sh <= 8'd1)};
            if (!s_leaf) begin
              depth <= d1 + 2'd2;
            end else begin
              depth <= d1;
            end
            st <= SRead;
          end
        end
        SRead: begin
          if (depth == '0) phase <= htsd_pkg::PhBody;
          st <= SIdle;
        end
        SStep: begin
          nxt <= child;
          st <= SDec;
        end
        SDec: begin
          bits <= bits + 1'b1;
          sh <= {1'b0, sh[7:1]};
          if (n_leaf && n_sym == endsym) begin
            // end symbol: flush any waiting symbol, then the end result; drop the rest
            cur <= '0; phase <= htsd_pkg::PhDone; hold <= 1'b0;
            if (hold) begin
              pend <= '{kind: htsd_pkg::KindSym, symbol: hsym, last: 1'b0};
              endq <= 1'b1;
            end else begin
              pend <= '{kind: htsd_pkg::KindEnd, symbol: 8'd0, last: 1'b1};
            end
            st <= SEmit;
          end else if (n_leaf && hold) begin
            // another symbol follows, so the waiting one is not the last
            cur <= '0;
            pend <= '{kind: htsd_pkg::KindSym, symbol: hsym, last: 1'b0};
            hsym <= n_sym;
            st <= SEmit;
          end else if (bits == 4'd7) begin
            cur <= n_leaf ? '0 : nxt;
            hold <= 1'b0;
            if (n_leaf || hold) begin
              pend <= '{kind: htsd_pkg::KindSym, symbol: n_leaf ? n_sym : hsym, last: 1'b1};
              st <= SEmit;
            end else st <= SIdle;
          end else begin
            cur <= n_leaf ? '0 : nxt;
            if (n_leaf) begin
              hold <= 1'b1; hsym <= n_sym;
            end
            st <= SStep;
          end
        end
        SEmit: if (free_ok) begin
          if (endq) begin
            pend <= '{kind: htsd_pkg::KindEnd, symbol: 8'd0, last: 1'b1};
            endq <= 1'b0;
          end else if (pend.last) begin
            st <= SIdle;
          end else if (bits == 4'd8) begin
            // byte done: the waiting symbol closes this request
            pend <= '{kind: htsd_pkg::KindSym, symbol: hsym, last: 1'b1};
            hold <= 1'b0;
          end else st <= SStep;
        end
        default: st <= SIdle;
      endcase
    end
  end

  // SStep needs nrd = entry of cur; SIdle and SEmit read cur, SDec reads the next node.

  // Assertions
  a_depth: assert property (@(posedge clk) disable iff (rst)
    depth <= SW'(MAX_DEPTH)) else $error("stack depth overflow");
  a_free: assert property (@(posedge clk) disable iff (rst)
    nfree <= CW'(MAX_NODES)) else $error("node count overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while waiting");
  a_load: assert property (@(posedge clk) disable iff (rst)
    load |-> free_ok) else $error("output overrun");
endmodule
